// ===== rtl/pwcs_pkg.sv =====
// shared types and constants for the pulse width command sender
package pwcs_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [7:0] CMD_BASE = 8'hE0;
  localparam logic [7:0] VOL_MAX = 8'h0F;

  localparam logic [TICK_W-1:0] START_LOW_RST = 16'd5000;
  localparam logic [TICK_W-1:0] LONG_PULSE_RST = 16'd600;
  localparam logic [TICK_W-1:0] SHORT_PULSE_RST = 16'd200;
  localparam logic [TICK_W-1:0] STOP_HIGH_RST = 16'd2000;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PLAY = 2'd1,
    OP_VOLUME = 2'd2,
    OP_MUTE = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LOW = 2'd0,
    REG_LONG_PULSE = 2'd1,
    REG_SHORT_PULSE = 2'd2,
    REG_STOP_HIGH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
    logic       busy_level;
  } in_item_t;

  typedef struct packed {
    logic data_line;
    logic ready_res;
    logic command_dropped;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] start_low_ticks;
    logic [TICK_W-1:0] long_pulse_ticks;
    logic [TICK_W-1:0] short_pulse_ticks;
    logic [TICK_W-1:0] stop_high_ticks;
  } timing_t;

endpackage

// ===== rtl/pwcs_frame.sv =====
// frame sequencer: per-tick state update and line level
module pwcs_frame (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  pwcs_pkg::in_item_t item,
  input  pwcs_pkg::timing_t  timing,
  output pwcs_pkg::out_item_t res
);
  import pwcs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_START = 3'd2,
    PH_BITA  = 3'd3,
    PH_BITB  = 3'd4,
    PH_STOP  = 3'd5
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [3:0]         bits_left_r, bits_left_nxt;
  logic [TICK_W-1:0]  timer_r, timer_nxt;
  logic               last;
  logic               ready;
  logic               dropped;
  logic               line;
  logic [7:0]         shifted;
  logic [3:0]         bits_dec;

  assign last = (timer_r <= {{(TICK_W-1){1'b0}}, 1'b1});
  assign shifted = {1'b0, shift_r[7:1]};
  assign bits_dec = bits_left_r - 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    bits_left_nxt = bits_left_r;
    timer_nxt = timer_r;
    line = 1'b1;
    ready = 1'b0;
    dropped = 1'b0;
    unique case (phase_r)
      PH_WAIT: begin
        if (item.busy_level) begin
          phase_nxt = PH_START;
          timer_nxt = timing.start_low_ticks;
        end
      end
      PH_START: begin
        line = 1'b0;
        if (last) begin
          bits_left_nxt = 4'd8;
          phase_nxt = PH_BITA;
          timer_nxt = shift_r[0] ? timing.long_pulse_ticks : timing.short_pulse_ticks;
        end else begin
          timer_nxt = timer_r - 1'b1;
        end
      end
      PH_BITA: begin
        if (last) begin
          phase_nxt = PH_BITB;
          timer_nxt = shift_r[0] ? timing.short_pulse_ticks : timing.long_pulse_ticks;
        end else begin
          timer_nxt = timer_r - 1'b1;
        end
      end
      PH_BITB: begin
        line = 1'b0;
        if (last) begin
          shift_nxt = shifted;
          bits_left_nxt = bits_dec;
          if (bits_dec == 4'd0) begin
            phase_nxt = PH_STOP;
            timer_nxt = timing.stop_high_ticks;
          end else begin
            phase_nxt = PH_BITA;
            timer_nxt = shifted[0] ? timing.long_pulse_ticks : timing.short_pulse_ticks;
          end
        end else begin
          timer_nxt = timer_r - 1'b1;
        end
      end
      PH_STOP: begin
        if (last) begin
          phase_nxt = PH_IDLE;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_r - 1'b1;
        end
      end
      default: begin
        // idle, and any unused code behaves as idle
        ready = 1'b1;
        phase_nxt = PH_IDLE;
        case (item.op)
          OP_PLAY: begin
            shift_nxt = item.value;
            phase_nxt = PH_WAIT;
          end
          OP_VOLUME: begin
            if (item.value <= VOL_MAX) begin
              shift_nxt = CMD_BASE + item.value;
              phase_nxt = PH_WAIT;
            end else begin
              dropped = 1'b1;
            end
          end
          OP_MUTE: begin
            shift_nxt = CMD_BASE;
            phase_nxt = PH_WAIT;
          end
          default: ;
        endcase
      end
    endcase
    if (!ready && (item.op != OP_TICK)) begin
      dropped = 1'b1;
    end
  end

  assign res.data_line = line;
  assign res.ready_res = ready;
  assign res.command_dropped = dropped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= '0;
      bits_left_r <= '0;
      timer_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      timer_r <= timer_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ready_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    res.ready_res |-> res.data_line)
    else $error("line low while idle");
  a_tick_never_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (item.op == OP_TICK) |-> !res.command_dropped)
    else $error("plain tick reported as dropped");
  a_bits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    bits_left_r <= 4'd8)
    else $error("bit count out of range");
  a_bits_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BITA || phase_r == PH_BITB) |-> (bits_left_r != 4'd0))
    else $error("bit phase with no bits left");
`endif

endmodule

// ===== rtl/pulse_width_command_sender.sv =====
// top level: configuration registers, frame sequencer and result buffer
// One result per accepted tick, one tick per clock while the result side keeps up.
// A tick's result is computed in the cycle it is accepted and held in an output
// register; a second buffer entry lets one more tick in while a result is stalled,
// after which in_stall rises until the output takes a result.
// Timing registers are written through the cfg port, which is always ready; the
// two-bit index selects one of the four registers. A new length takes effect the
// next time its segment starts.
module pulse_width_command_sender (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pwcs_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pwcs_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwcs_pkg::TICK_W-1:0]         cfg_data
);
  import pwcs_pkg::*;

  timing_t   timing_r;
  out_item_t res;
  out_item_t main_r;
  out_item_t skid_r;
  logic      main_valid_r;
  logic      skid_valid_r;
  logic      in_xfer;
  logic      out_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.start_low_ticks <= START_LOW_RST;
      timing_r.long_pulse_ticks <= LONG_PULSE_RST;
      timing_r.short_pulse_ticks <= SHORT_PULSE_RST;
      timing_r.stop_high_ticks <= STOP_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_LOW:   timing_r.start_low_ticks <= cfg_data;
        REG_LONG_PULSE:  timing_r.long_pulse_ticks <= cfg_data;
        REG_SHORT_PULSE: timing_r.short_pulse_ticks <= cfg_data;
        REG_STOP_HIGH:   timing_r.stop_high_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_xfer = in_valid && !in_stall;
  assign out_valid = main_valid_r;
  assign out_item = main_r;
  assign out_xfer = main_valid_r && !out_stall;

  pwcs_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_xfer),
    .item    (in_item),
    .timing  (timing_r),
    .res     (res)
  );

  // two-entry result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_xfer) begin
          main_valid_r <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (in_xfer) begin
        if (!main_valid_r || out_xfer) begin
          main_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_xfer) begin
        main_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_xfer) begin
        main_r <= skid_r;
      end
    end else if (in_xfer) begin
      if (!main_valid_r || out_xfer) begin
        main_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held with empty output register");
  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (out_valid && !skid_valid_r))
    else $error("skid entry not moved to output");
  a_fill_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !out_valid) |=> (out_valid && !skid_valid_r))
    else $error("accepted tick not presented");
`endif

endmodule
